FILE: rtl/core/rfr_pkg.sv
// Shared types, constants and the CRC16 byte update for the request frame receiver.
// No dependencies; rfr_front, rfr_back and request_frame_receiver refer to this package by scoped names.
package rfr_pkg;

    localparam logic [23:0] SYNC_HEAD       = 24'hDEADBE;
    localparam logic [7:0]  SYNC_TAIL       = 8'hEF;
    localparam logic [15:0] CRC_SEED        = 16'hFFFF;
    localparam logic [15:0] CRC_POLY        = 16'h8408;
    localparam logic [31:0] DEFAULT_MAX_LEN = 32'd2097152;
    localparam logic [2:0]  HDR_LAST        = 3'd4;

    localparam logic [7:0] CMD_A = 8'h01;
    localparam logic [7:0] CMD_B = 8'h02;
    localparam logic [7:0] CMD_C = 8'h03;
    localparam logic [7:0] CMD_D = 8'h04;
    localparam logic [7:0] CMD_E = 8'h07;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD     = 2'd1;
    localparam logic [1:0] ST_TOO_BIG = 2'd2;
    localparam logic [1:0] ST_UNKNOWN = 2'd3;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_HEADER,
        PH_PAYLOAD,
        PH_TRL_LO,
        PH_TRL_HI
    } phase_t;

    typedef enum logic [2:0] {
        OP_FOLD_SEED,
        OP_FOLD,
        OP_PAYLOAD,
        OP_TRL_LO,
        OP_TRL_HI,
        OP_TOO_BIG
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [7:0]  data;
        logic [7:0]  cmd;
        logic [31:0] len;
    } work_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  data;
        logic [7:0]  cmd;
        logic [31:0] len;
        logic [1:0]  status;
        logic        last;
    } result_t;

    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = ~crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return ~c;
    endfunction

    function automatic logic cmd_known(input logic [7:0] c);
        return (c == CMD_A) || (c == CMD_B) || (c == CMD_C) || (c == CMD_D) || (c == CMD_E);
    endfunction

endpackage

FILE: rtl/core/rfr_fifo.sv
// Small show-ahead queue of registered slots, used between front and back and at the output.
// Depends on nothing but its parameters.
module rfr_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count above depth");

    a_write_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (do_wr && !do_rd) |=> !empty)
        else $error("queue empty after a lone write");

endmodule

FILE: rtl/core/rfr_front.sv
// Front end: sync hunt, header parse, length check and byte classification.
// Depends on rfr_pkg; emits one work entry per byte that matters to the back end.
module rfr_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           acc,
    input  logic [7:0]     rx_byte,
    input  logic [31:0]    max_len,
    output logic           wk_push,
    output rfr_pkg::work_t wk
);
    rfr_pkg::phase_t phase_reg, phase_next;
    logic [23:0]     win_reg, win_next;
    logic [2:0]      hc_reg, hc_next;
    logic [7:0]      cmd_reg, cmd_next;
    logic [31:0]     len_reg, len_next;
    logic [31:0]     left_reg, left_next;
    logic [7:0]      hdr_cmd;
    logic [31:0]     hdr_len;
    logic [31:0]     left_dec;
    logic            sync_hit;
    logic            hdr_done;
    logic            too_big;

    // header bytes: command first, then length LSB first
    always_comb
    begin
        hdr_cmd = cmd_reg;
        hdr_len = len_reg;
        case (hc_reg)
            3'd0: begin hdr_cmd = rx_byte; hdr_len = '0; end
            3'd1: hdr_len[7:0]   = rx_byte;
            3'd2: hdr_len[15:8]  = rx_byte;
            3'd3: hdr_len[23:16] = rx_byte;
            default: hdr_len[31:24] = rx_byte;
        endcase
    end

    assign sync_hit = (win_reg == rfr_pkg::SYNC_HEAD) && (rx_byte == rfr_pkg::SYNC_TAIL);
    assign hdr_done = (hc_reg == rfr_pkg::HDR_LAST);
    assign too_big  = hdr_len > max_len;
    assign left_dec = left_reg - 32'd1;

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (acc)
        begin
            unique case (phase_reg)
                rfr_pkg::PH_HEADER:
                begin
                    if (hdr_done)
                    begin
                        if (too_big)
                            phase_next = rfr_pkg::PH_HUNT;
                        else if (hdr_len == '0)
                            phase_next = rfr_pkg::PH_TRL_LO;
                        else
                            phase_next = rfr_pkg::PH_PAYLOAD;
                    end
                end
                rfr_pkg::PH_PAYLOAD:
                begin
                    if (left_dec == '0)
                        phase_next = rfr_pkg::PH_TRL_LO;
                end
                rfr_pkg::PH_TRL_LO: phase_next = rfr_pkg::PH_TRL_HI;
                rfr_pkg::PH_TRL_HI: phase_next = rfr_pkg::PH_HUNT;
                default:
                begin
                    phase_next = sync_hit ? rfr_pkg::PH_HEADER : rfr_pkg::PH_HUNT;
                end
            endcase
        end
    end

    // datapath updates and work entry
    always_comb
    begin
        win_next  = win_reg;
        hc_next   = hc_reg;
        cmd_next  = cmd_reg;
        len_next  = len_reg;
        left_next = left_reg;
        wk_push   = 1'b0;
        wk.op     = rfr_pkg::OP_FOLD;
        wk.data   = rx_byte;
        wk.cmd    = cmd_reg;
        wk.len    = len_reg;
        if (acc)
        begin
            unique case (phase_reg)
                rfr_pkg::PH_HEADER:
                begin
                    wk_push  = 1'b1;
                    wk.op    = (hc_reg == '0) ? rfr_pkg::OP_FOLD_SEED : rfr_pkg::OP_FOLD;
                    wk.cmd   = hdr_cmd;
                    wk.len   = hdr_len;
                    cmd_next = hdr_cmd;
                    len_next = hdr_len;
                    hc_next  = hc_reg + 3'd1;
                    if (hdr_done)
                    begin
                        hc_next   = '0;
                        left_next = hdr_len;
                        if (too_big)
                        begin
                            wk.op    = rfr_pkg::OP_TOO_BIG;
                            win_next = '0;
                        end
                    end
                end
                rfr_pkg::PH_PAYLOAD:
                begin
                    wk_push   = 1'b1;
                    wk.op     = rfr_pkg::OP_PAYLOAD;
                    left_next = left_dec;
                end
                rfr_pkg::PH_TRL_LO:
                begin
                    wk_push = 1'b1;
                    wk.op   = rfr_pkg::OP_TRL_LO;
                end
                rfr_pkg::PH_TRL_HI:
                begin
                    wk_push  = 1'b1;
                    wk.op    = rfr_pkg::OP_TRL_HI;
                    win_next = '0;
                end
                default:
                begin
                    if (sync_hit)
                    begin
                        hc_next  = '0;
                        win_next = '0;
                    end
                    else
                    begin
                        win_next = {win_reg[15:0], rx_byte};
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= rfr_pkg::PH_HUNT;
            win_reg   <= '0;
            hc_reg    <= '0;
            cmd_reg   <= '0;
            len_reg   <= '0;
            left_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            win_reg   <= win_next;
            hc_reg    <= hc_next;
            cmd_reg   <= cmd_next;
            len_reg   <= len_next;
            left_reg  <= left_next;
        end
    end

    a_payload_left: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == rfr_pkg::PH_PAYLOAD) |-> (left_reg != '0))
        else $error("payload phase with no bytes left");

    a_header_count: assert property (@(posedge clk) disable iff (!rst_n)
        hc_reg <= rfr_pkg::HDR_LAST)
        else $error("header count out of range");

endmodule

FILE: rtl/core/rfr_back.sv
// Back end: CRC16 over header and payload, trailer compare, result formatting.
// Depends on rfr_pkg; drains the work queue and fills the result queue.
module rfr_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wk_valid,
    input  rfr_pkg::work_t   wk,
    output logic             wk_pop,
    input  logic             res_full,
    output logic             res_push,
    output rfr_pkg::result_t res
);
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  trl_lo_reg, trl_lo_next;
    logic [15:0] wire_crc;

    assign wk_pop   = wk_valid && !res_full;
    assign wire_crc = {wk.data, trl_lo_reg};

    always_comb
    begin
        crc_next     = crc_reg;
        trl_lo_next  = trl_lo_reg;
        res_push     = 1'b0;
        res.kind     = rfr_pkg::KIND_END;
        res.data     = '0;
        res.cmd      = wk.cmd;
        res.len      = wk.len;
        res.status   = rfr_pkg::ST_OK;
        res.last     = 1'b1;
        if (wk_pop)
        begin
            unique case (wk.op) inside
                rfr_pkg::OP_FOLD_SEED:
                begin
                    crc_next = rfr_pkg::crc_fold(rfr_pkg::CRC_SEED, wk.data);
                end
                rfr_pkg::OP_FOLD:
                begin
                    crc_next = rfr_pkg::crc_fold(crc_reg, wk.data);
                end
                rfr_pkg::OP_PAYLOAD:
                begin
                    crc_next = rfr_pkg::crc_fold(crc_reg, wk.data);
                    res_push = 1'b1;
                    res.kind = rfr_pkg::KIND_DATA;
                    res.data = wk.data;
                    res.last = 1'b0;
                end
                rfr_pkg::OP_TRL_LO:
                begin
                    trl_lo_next = wk.data;
                end
                rfr_pkg::OP_TRL_HI:
                begin
                    res_push = 1'b1;
                    if (wire_crc != crc_reg)
                        res.status = rfr_pkg::ST_BAD;
                    else if (rfr_pkg::cmd_known(wk.cmd))
                        res.status = rfr_pkg::ST_OK;
                    else
                        res.status = rfr_pkg::ST_UNKNOWN;
                end
                rfr_pkg::OP_TOO_BIG:
                begin
                    res_push   = 1'b1;
                    res.status = rfr_pkg::ST_TOO_BIG;
                end
                default:
                begin
                    res_push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg    <= rfr_pkg::CRC_SEED;
            trl_lo_reg <= '0;
        end
        else
        begin
            crc_reg    <= crc_next;
            trl_lo_reg <= trl_lo_next;
        end
    end

    a_push_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> (wk_valid && !res_full))
        else $error("result produced without a work transfer");

    a_end_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && res.kind == rfr_pkg::KIND_END) |-> (res.last && res.data == '0))
        else $error("malformed end-of-frame result");

    a_seed_after_sync: assert property (@(posedge clk) disable iff (!rst_n)
        (wk_pop && wk.op == rfr_pkg::OP_FOLD_SEED)
        |=> (crc_reg == rfr_pkg::crc_fold(rfr_pkg::CRC_SEED, $past(wk.data))))
        else $error("seed fold lost");

endmodule

FILE: rtl/core/request_frame_receiver.sv
// Request frame receiver: byte-serial deframer for DE AD BE EF | cmd | len | payload | crc.
// Depends on rfr_pkg, rfr_front, rfr_back and rfr_fifo.
//
// One received byte is taken per transfer on the push/full side, and the block sustains one
// byte per clock cycle while full is low: the front end hunts for the sync word, parses the
// command and the little-endian 32-bit length, checks the length against the limit register and
// classifies each byte; a short work queue (FRONT_DEPTH entries) carries the classified bytes
// to the back end, which runs the byte-wide CRC16 (reflected poly 0x8408, seed 0xFFFF,
// complemented per byte), compares it with the little-endian trailer and writes results into
// the result queue (OUT_DEPTH entries). A payload byte passes through the work queue and then
// the result queue on its way out. Each payload byte yields a result with out_kind 0;
// each frame ends with one result with out_kind 1, last 1 and the frame status: ok, bad_frame
// on CRC mismatch, unknown_cmd for commands other than 1, 2, 3, 4, 7, or too_big right after
// the last length byte when the length exceeds the limit (no payload or trailer is taken then).
// Header, trailer and hunt bytes produce no result. After any frame end the sync word must
// arrive complete again. full rises only when the work queue backs up, which happens when the
// result side is not drained. The limit register is written through cfg_valid/cfg_data at any
// time (cfg_ready is always high) but should change only while no frame is in flight.
module request_frame_receiver #(
    parameter int FRONT_DEPTH = 2,
    parameter int OUT_DEPTH   = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  rx_byte,
    output logic        empty,
    input  logic        pop,
    output logic        out_kind,
    output logic [7:0]  out_byte,
    output logic [7:0]  frame_cmd,
    output logic [31:0] frame_len,
    output logic [1:0]  frame_status,
    output logic        last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);
    logic [31:0]      max_len_reg, max_len_next;
    logic             acc;
    logic             wk_push, wk_pop, wk_empty;
    rfr_pkg::work_t   wk_in, wk_out;
    logic             res_push, res_full;
    rfr_pkg::result_t res_in, res_out;

    // limit register: always ready, take the write on transfer
    assign cfg_ready    = 1'b1;
    assign max_len_next = (cfg_valid && cfg_ready) ? cfg_data : max_len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= rfr_pkg::DEFAULT_MAX_LEN;
        end
        else
        begin
            max_len_reg <= max_len_next;
        end
    end

    assign acc = push && !full;

    rfr_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .acc     (acc),
        .rx_byte (rx_byte),
        .max_len (max_len_reg),
        .wk_push (wk_push),
        .wk      (wk_in)
    );

    // work queue between front and back; its full flag stalls the input side
    rfr_fifo #(
        .WIDTH ($bits(rfr_pkg::work_t)),
        .DEPTH (FRONT_DEPTH)
    ) u_work_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wk_push),
        .wr_data (wk_in),
        .rd_en   (wk_pop),
        .rd_data (wk_out),
        .full    (full),
        .empty   (wk_empty)
    );

    rfr_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .wk_valid (!wk_empty),
        .wk       (wk_out),
        .wk_pop   (wk_pop),
        .res_full (res_full),
        .res_push (res_push),
        .res      (res_in)
    );

    // result queue: holds finished results until popped
    rfr_fifo #(
        .WIDTH ($bits(rfr_pkg::result_t)),
        .DEPTH (OUT_DEPTH)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_in),
        .rd_en   (pop),
        .rd_data (res_out),
        .full    (res_full),
        .empty   (empty)
    );

    assign out_kind     = res_out.kind;
    assign out_byte     = res_out.data;
    assign frame_cmd    = res_out.cmd;
    assign frame_len    = res_out.len;
    assign frame_status = res_out.status;
    assign last         = res_out.last;

    a_data_result: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && out_kind == rfr_pkg::KIND_DATA) |-> (!last && frame_status == rfr_pkg::ST_OK))
        else $error("payload result carries end-of-frame marks");

    a_end_result: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && out_kind == rfr_pkg::KIND_END) |-> (last && out_byte == '0))
        else $error("end-of-frame result malformed");

    a_full_from_backlog: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !wk_empty)
        else $error("input stalled with empty work queue");

endmodule

FILE: verif/tb.sv
// Testbench for request_frame_receiver: sync hunt, header parse, length limit and CRC16 check.
// Depends on rfr_pkg and the request_frame_receiver RTL; self-checking against an in-bench
// deframer model, random bytes from $urandom.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Directed rows: where the byte comes from and what result is owed for it.
    typedef enum logic [1:0] {
        SRC_LIT,
        SRC_CRC_LO,
        SRC_CRC_HI,
        SRC_CRC_HI_BAD
    } byte_src_t;

    typedef enum logic [1:0] {
        WANT_MODEL,
        WANT_NONE,
        WANT_END
    } want_t;

    typedef struct {
        byte_src_t   src;
        logic [7:0]  lit;
        want_t       want;
        logic [7:0]  cmd;
        logic [31:0] len;
        logic [1:0]  status;
    } step_row_t;

    localparam int PHASES       = 5;
    localparam int PHASE_BYTES  = 330;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE       = 10;
    localparam int MAX_SMALL    = 12;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [7:0]  rx_byte;
    logic        empty;
    logic        pop;
    logic        out_kind;
    logic [7:0]  out_byte;
    logic [7:0]  frame_cmd;
    logic [31:0] frame_len;
    logic [1:0]  frame_status;
    logic        last;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] cfg_data;

    // Deframer model state, mirrors what the block holds between bytes.
    rfr_pkg::phase_t fr_phase;
    logic [23:0]     fr_window;
    logic [2:0]      fr_hdr_cnt;
    logic [7:0]      fr_cmd;
    logic [31:0]     fr_len;
    logic [31:0]     fr_left;
    logic [15:0]     fr_crc;
    logic [7:0]      fr_trl_lo;
    logic [31:0]     fr_max;

    rfr_pkg::result_t owed[$];   // results the block still has to deliver, oldest first
    step_row_t        script[$];
    int               fails;
    int               frame_bytes;    // bytes taken in the current phase
    int unsigned      send_idle_pct;
    int unsigned      recv_stall_pct;
    bit               hold_req;

    request_frame_receiver u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .rx_byte      (rx_byte),
        .empty        (empty),
        .pop          (pop),
        .out_kind     (out_kind),
        .out_byte     (out_byte),
        .frame_cmd    (frame_cmd),
        .frame_len    (frame_len),
        .frame_status (frame_status),
        .last         (last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Bitwise LSB-first form of the reflected CRC16; register held complemented.
    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = ~crc;
        for (int i = 0; i < 8; i++)
        begin
            fb = c[0] ^ b[i];
            c  = c >> 1;
            if (fb)
                c = c ^ rfr_pkg::CRC_POLY;
        end
        return ~c;
    endfunction

    function automatic bit is_known_cmd(input logic [7:0] c);
        case (c)
            rfr_pkg::CMD_A, rfr_pkg::CMD_B, rfr_pkg::CMD_C,
            rfr_pkg::CMD_D, rfr_pkg::CMD_E: return 1'b1;
            default:                        return 1'b0;
        endcase
    endfunction

    function automatic logic [7:0] sync_byte(input int k);
        logic [31:0] w;
        w = {rfr_pkg::SYNC_HEAD, rfr_pkg::SYNC_TAIL};
        return w[31 - 8 * k -: 8];
    endfunction

    // Advance the deframer model by one byte; flag and fill the result it causes.
    task automatic deframe_byte(input logic [7:0] b, output bit has,
                                output rfr_pkg::result_t res);
        logic [1:0] st;
        has = 1'b0;
        res = '0;
        case (fr_phase)
            rfr_pkg::PH_HEADER:
            begin
                fr_crc = crc_step(fr_crc, b);
                if (fr_hdr_cnt == 3'd0)
                begin
                    fr_cmd = b;
                    fr_len = '0;
                end
                else
                    fr_len[8 * (fr_hdr_cnt - 1) +: 8] = b;
                if (fr_hdr_cnt == rfr_pkg::HDR_LAST)
                begin
                    fr_hdr_cnt = 3'd0;
                    if (fr_len > fr_max)
                    begin
                        // too long: end the frame on the last length byte, rescan
                        fr_phase  = rfr_pkg::PH_HUNT;
                        fr_window = '0;
                        has = 1'b1;
                        res = '{kind: rfr_pkg::KIND_END, data: 8'h00, cmd: fr_cmd,
                                len: fr_len, status: rfr_pkg::ST_TOO_BIG, last: 1'b1};
                    end
                    else
                    begin
                        fr_left  = fr_len;
                        fr_phase = (fr_len == 0) ? rfr_pkg::PH_TRL_LO : rfr_pkg::PH_PAYLOAD;
                    end
                end
                else
                    fr_hdr_cnt = fr_hdr_cnt + 3'd1;
            end
            rfr_pkg::PH_PAYLOAD:
            begin
                fr_crc = crc_step(fr_crc, b);
                if (fr_left != 0)
                    fr_left = fr_left - 1;
                if (fr_left == 0)
                    fr_phase = rfr_pkg::PH_TRL_LO;
                has = 1'b1;
                res = '{kind: rfr_pkg::KIND_DATA, data: b, cmd: fr_cmd, len: fr_len,
                        status: rfr_pkg::ST_OK, last: 1'b0};
            end
            rfr_pkg::PH_TRL_LO:
            begin
                fr_trl_lo = b;
                fr_phase  = rfr_pkg::PH_TRL_HI;
            end
            rfr_pkg::PH_TRL_HI:
            begin
                // CRC mismatch wins over an unknown command
                if ({b, fr_trl_lo} != fr_crc)
                    st = rfr_pkg::ST_BAD;
                else if (is_known_cmd(fr_cmd))
                    st = rfr_pkg::ST_OK;
                else
                    st = rfr_pkg::ST_UNKNOWN;
                fr_phase  = rfr_pkg::PH_HUNT;
                fr_window = '0;
                has = 1'b1;
                res = '{kind: rfr_pkg::KIND_END, data: 8'h00, cmd: fr_cmd, len: fr_len,
                        status: st, last: 1'b1};
            end
            default:
            begin
                if (fr_window == rfr_pkg::SYNC_HEAD && b == rfr_pkg::SYNC_TAIL)
                begin
                    fr_phase   = rfr_pkg::PH_HEADER;
                    fr_hdr_cnt = 3'd0;
                    fr_crc     = rfr_pkg::CRC_SEED;
                    fr_window  = '0;
                end
                else
                begin
                    fr_phase  = rfr_pkg::PH_HUNT;
                    fr_window = {fr_window[15:0], b};
                end
            end
        endcase
    endtask

    // Offer one byte, hold it until the block takes it, then run the model on it.
    // Push stays high after the transfer so back-to-back bytes need no extra edge.
    task automatic offer_byte(input logic [7:0] b, output bit has,
                              output rfr_pkg::result_t res);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push    <= 1'b1;
        rx_byte <= b;
        do
            @(posedge clk);
        while (full);
        frame_bytes++;
        deframe_byte(b, has, res);
    endtask

    task automatic feed(input logic [7:0] b);
        bit               has;
        rfr_pkg::result_t res;
        offer_byte(b, has, res);
        if (has)
            owed.push_back(res);
    endtask

    task automatic wait_drained();
        while (owed.size() != 0)
            @(posedge clk);
        // header and trailer bytes owe nothing but may still sit in the pipe
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_max_len(input logic [31:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        fr_max = v;
        cfg_valid <= 1'b0;
    endtask

    task automatic add_row(input byte_src_t src, input logic [7:0] lit, input want_t want,
                           input logic [7:0] cmd = 8'h00, input logic [31:0] len = '0,
                           input logic [1:0] status = rfr_pkg::ST_OK);
        step_row_t r;
        r = '{src: src, lit: lit, want: want, cmd: cmd, len: len, status: status};
        script.push_back(r);
    endtask

    task automatic check_field(input string name, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (got_v !== want_v)
        begin
            $error("%s: expected %0h, got %0h", name, want_v, got_v);
            fails++;
        end
    endtask

    // One random frame: mostly well formed with random content, the rest noise,
    // a broken sync word, an unknown command, a length over the limit or a bad trailer.
    task automatic send_frame();
        int unsigned roll;
        int unsigned n;
        logic [7:0]  cmd;
        logic [31:0] len;
        logic [31:0] cap;
        logic [15:0] trl;
        logic [7:0]  b;
        roll = $urandom_range(99);
        if (roll < 8)
        begin
            n = $urandom_range(8, 1);
            repeat (n) feed(8'($urandom_range(255)));
            return;
        end
        if (roll < 18)
        begin
            // stop the sync word short; the window has to slide past it
            n = $urandom_range(3, 1);
            for (int k = 0; k < n; k++)
                feed(sync_byte(k));
            if ($urandom_range(1) == 0)
            begin
                // anything but the sync tail, or the short word would close the window
                b = 8'($urandom_range(255));
                if (b == rfr_pkg::SYNC_TAIL)
                    b = 8'h00;
                feed(b);
            end
        end
        for (int k = 0; k < 4; k++)
            feed(sync_byte(k));

        if ($urandom_range(99) < 75)
        begin
            case ($urandom_range(4))
                0:       cmd = rfr_pkg::CMD_A;
                1:       cmd = rfr_pkg::CMD_B;
                2:       cmd = rfr_pkg::CMD_C;
                3:       cmd = rfr_pkg::CMD_D;
                default: cmd = rfr_pkg::CMD_E;
            endcase
        end
        else
            cmd = 8'($urandom_range(255));

        if (fr_max != 32'hFFFF_FFFF && $urandom_range(99) < 15)
        begin
            case ($urandom_range(2))
                0:       len = fr_max + 1;
                1:       len = 32'hFFFF_FFFF;
                default: len = fr_max + 1 + ($urandom() % (32'hFFFF_FFFF - fr_max));
            endcase
        end
        else
        begin
            cap = (fr_max < MAX_SMALL) ? fr_max : MAX_SMALL;
            len = $urandom_range(cap, 0);
            if (fr_max <= 2 * MAX_SMALL && $urandom_range(4) == 0)
                len = fr_max;
        end

        feed(cmd);
        for (int k = 0; k < 4; k++)
            feed(len[8 * k +: 8]);
        if (len > fr_max)
            return;

        for (int i = 0; i < len; i++)
        begin
            // sprinkle sync bytes into the payload; they must pass as data
            if ($urandom_range(9) == 0)
                feed(sync_byte($urandom_range(3)));
            else
                feed(8'($urandom_range(255)));
        end
        trl = fr_crc;
        if ($urandom_range(99) < 15)
            trl = trl ^ (16'h0001 << $urandom_range(15));
        feed(trl[7:0]);
        feed(trl[15:8]);
    endtask

    // Result side: check every transfer out, stall at random, and hold off
    // for a long stretch when asked so the block backs up into full.
    initial
    begin
        int unsigned      hold_left;
        rfr_pkg::result_t want;
        hold_left = 0;
        pop = 1'b0;
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
            begin
                if (owed.size() == 0)
                begin
                    $error("unexpected result: kind %0d byte %0h status %0d",
                           out_kind, out_byte, frame_status);
                    fails++;
                end
                else
                begin
                    want = owed.pop_front();
                    check_field("out_kind", 32'(want.kind), 32'(out_kind));
                    check_field("out_byte", 32'(want.data), 32'(out_byte));
                    check_field("frame_cmd", 32'(want.cmd), 32'(frame_cmd));
                    check_field("frame_len", want.len, frame_len);
                    check_field("frame_status", 32'(want.status), 32'(frame_status));
                    check_field("last", 32'(want.last), 32'(last));
                end
            end
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
                pop <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Stimulus: reset, directed frames, then random phases with different limits
    // and idle patterns. Limit writes happen only once everything owed has arrived.
    initial
    begin
        int unsigned      send_plan [PHASES];
        int unsigned      recv_plan [PHASES];
        logic [31:0]      max_plan  [PHASES];
        step_row_t        r;
        logic [7:0]       b;
        bit               has;
        rfr_pkg::result_t res;

        send_plan = '{0, 74, 0, 33, 0};
        recv_plan = '{0, 0, 74, 33, 0};
        max_plan  = '{$urandom_range(16, 4), 32'd0, 32'hFFFF_FFFF, rfr_pkg::DEFAULT_MAX_LEN,
                      $urandom_range(8, 1)};

        rst_n     = 1'b0;
        push      = 1'b0;
        rx_byte   = 8'h00;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        fails          = 0;
        frame_bytes    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req       = 1'b0;

        fr_phase   = rfr_pkg::PH_HUNT;
        fr_window  = '0;
        fr_hdr_cnt = '0;
        fr_cmd     = '0;
        fr_len     = '0;
        fr_left    = '0;
        fr_crc     = rfr_pkg::CRC_SEED;
        fr_trl_lo  = '0;
        fr_max     = rfr_pkg::DEFAULT_MAX_LEN;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Largest length and all-ones bytes under the reset limit: too_big on the
        // last length byte, nothing else taken.
        for (int k = 0; k < 4; k++)
            add_row(SRC_LIT, sync_byte(k), WANT_NONE);
        add_row(SRC_LIT, 8'hFF, WANT_NONE);
        repeat (3) add_row(SRC_LIT, 8'hFF, WANT_NONE);
        add_row(SRC_LIT, 8'hFF, WANT_END, 8'hFF, 32'hFFFF_FFFF, rfr_pkg::ST_TOO_BIG);
        // Zero length straight into the trailer, good CRC, command zero: unknown_cmd.
        for (int k = 0; k < 4; k++)
            add_row(SRC_LIT, sync_byte(k), WANT_NONE);
        repeat (5) add_row(SRC_LIT, 8'h00, WANT_NONE);
        add_row(SRC_CRC_LO, 8'h00, WANT_NONE);
        add_row(SRC_CRC_HI, 8'h00, WANT_END, 8'h00, 32'd0, rfr_pkg::ST_UNKNOWN);
        // One payload byte that is a sync byte, then a broken trailer: bad_frame.
        for (int k = 0; k < 4; k++)
            add_row(SRC_LIT, sync_byte(k), WANT_NONE);
        add_row(SRC_LIT, rfr_pkg::CMD_A, WANT_NONE);
        add_row(SRC_LIT, 8'h01, WANT_NONE);
        repeat (3) add_row(SRC_LIT, 8'h00, WANT_NONE);
        add_row(SRC_LIT, rfr_pkg::SYNC_TAIL, WANT_MODEL);
        add_row(SRC_CRC_LO, 8'h00, WANT_NONE);
        add_row(SRC_CRC_HI_BAD, 8'h00, WANT_END, rfr_pkg::CMD_A, 32'd1, rfr_pkg::ST_BAD);

        foreach (script[i])
        begin
            r = script[i];
            case (r.src)
                SRC_CRC_LO:     b = fr_crc[7:0];
                SRC_CRC_HI:     b = fr_crc[15:8];
                SRC_CRC_HI_BAD: b = ~fr_crc[15:8];
                default:        b = r.lit;
            endcase
            offer_byte(b, has, res);
            case (r.want)
                WANT_MODEL:
                    if (has)
                        owed.push_back(res);
                WANT_END:
                    owed.push_back('{kind: rfr_pkg::KIND_END, data: 8'h00, cmd: r.cmd,
                                     len: r.len, status: r.status, last: 1'b1});
                default: ;
            endcase
        end
        push <= 1'b0;
        wait_drained();

        for (int p = 0; p < PHASES; p++)
        begin
            send_idle_pct  = send_plan[p];
            recv_stall_pct = recv_plan[p];
            // last phase: stall the result side long enough to fill both queues
            if (p == PHASES - 1)
                hold_req = 1'b1;
            set_max_len(max_plan[p]);
            frame_bytes = 0;
            while (frame_bytes < PHASE_BYTES)
                send_frame();
            // finish any frame in flight so the next limit write lands between frames
            while (fr_phase != rfr_pkg::PH_HUNT)
                feed(8'h00);
            push <= 1'b0;
            wait_drained();
        end

        // drain with no stalls so a stray extra result gets popped and flagged
        recv_stall_pct = 0;
        wait_drained();
        if (fails == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Run limit, far above the slowest correct run.
    initial
    begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/rfr_pkg.sv
rtl/core/rfr_fifo.sv
rtl/core/rfr_front.sv
rtl/core/rfr_back.sv
rtl/core/request_frame_receiver.sv
verif/tb.sv
